// ===== sv/mahc_pkg.sv =====
// ----------------------------------------------------------------------------
// mahc_pkg
// Shared types, field widths and codes for the audio health check block.
// ----------------------------------------------------------------------------
`default_nettype none

package mahc_pkg;

  // field widths
  localparam int SAMPLE_W   = 16;
  localparam int CHAN_W     = 3;
  localparam int FRAME_W    = 32;
  localparam int KIND_W     = 2;
  localparam int ENERGY_W   = 42;
  localparam int WIN_W      = 43;
  localparam int CMP_W      = WIN_W + 3;
  localparam int SQ_W       = 31;
  localparam int COUNT_W    = 4;
  localparam int HALF_W     = 12;
  localparam int HALF_CMP_W = HALF_W + 1;
  localparam int NCH_W      = 6;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;

  // stream layout
  localparam int S_TDATA_W = 24;
  localparam int M_TDATA_W = 40;
  localparam int S_SAMPLE_LSB = 0;
  localparam int S_CHAN_LSB   = SAMPLE_W;
  localparam int M_PAYLOAD_W  = KIND_W + CHAN_W + FRAME_W;

  // parameter defaults
  localparam int MAX_CHANNELS_DEF    = 8;
  localparam int MAX_HALF_WINDOW_DEF = 2048;

  // register reset values
  localparam logic [COUNT_W-1:0]    CHANNEL_COUNT_RST = 4'd2;
  localparam logic [HALF_W-1:0]     HALF_LENGTH_RST   = 12'd800;
  localparam logic [SAMPLE_W-1:0]   THRESHOLD_RST     = 16'd0;

  // clip limits
  localparam logic signed [SAMPLE_W-1:0] CLIP_POS = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] CLIP_NEG = -16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_LENGTH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD     = 2'd2;

  typedef enum logic [KIND_W-1:0] {
    EV_CLIP  = 2'd0,
    EV_ZERO  = 2'd1,
    EV_LOW   = 2'd2,
    EV_IMBAL = 2'd3
  } event_kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ACCUM,
    ST_ZERO,
    ST_LOW,
    ST_RDI,
    ST_LDA,
    ST_CMP,
    ST_FLUSH
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic        capture;
    logic        square;
    logic        accum;
    logic        wsum;
    logic        shift;
    logic        push;
    event_kind_t kind;
    logic        pair_init;
    logic        rd_i;
    logic        load_a;
    logic        next_k;
    logic        next_i;
    logic        flush;
    logic        advance;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_range;
    logic clip;
    logic zero_ev;
    logic low_ev;
    logic win_end;
    logic half_end;
    logic last_ch;
    logic nch_ge2;
    logic imb;
    logic k_last;
    logic i_last;
    logic can_push;
  } sts_t;

endpackage

`default_nettype wire

// ===== sv/mahc_datapath.sv =====
// ----------------------------------------------------------------------------
// mahc_datapath
// Config registers, per-channel energy and flag state, window energy memory,
// pair compare and the pending/output event registers.
// ----------------------------------------------------------------------------
`default_nettype none

module mahc_datapath #(
  parameter int MAX_CHANNELS    = mahc_pkg::MAX_CHANNELS_DEF,
  parameter int MAX_HALF_WINDOW = mahc_pkg::MAX_HALF_WINDOW_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [mahc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [mahc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic [mahc_pkg::S_TDATA_W-1:0]   s_tdata,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic [mahc_pkg::M_TDATA_W-1:0]        m_tdata,
  output logic                                  m_tlast,
  input  wire mahc_pkg::cmd_t                   cmd,
  output mahc_pkg::sts_t                        sts
);

  localparam int CW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int PW = (MAX_HALF_WINDOW > 1) ? $clog2(MAX_HALF_WINDOW) : 1;
  localparam int EW = mahc_pkg::ENERGY_W;
  localparam int WW = mahc_pkg::WIN_W;
  localparam int XW = mahc_pkg::CMP_W;
  localparam int NW = mahc_pkg::NCH_W;
  localparam int HW = mahc_pkg::HALF_CMP_W;
  localparam int SW = mahc_pkg::SAMPLE_W;

  // config registers
  logic [mahc_pkg::COUNT_W-1:0] channel_count;
  logic [mahc_pkg::HALF_W-1:0]  window_half_length;
  logic signed [SW-1:0]         level_threshold;

  // item registers
  logic signed [SW-1:0]             smp;
  logic [mahc_pkg::CHAN_W-1:0]      chn;
  logic [mahc_pkg::SQ_W-1:0]        sq;
  logic signed [2*SW-1:0]           prod;

  // per-channel state
  logic [EW-1:0]           he_now  [MAX_CHANNELS];
  logic [EW-1:0]           he_prev [MAX_CHANNELS];
  logic [MAX_CHANNELS-1:0] nz_now, nz_prev, ab_now, ab_prev;
  logic [WW-1:0]           we_mem  [MAX_CHANNELS];
  logic [WW-1:0]           rdata;
  logic [CW-1:0]           raddr;

  // window position
  logic [PW-1:0]                 half_position;
  logic                          first_half_done;
  logic [mahc_pkg::FRAME_W-1:0]  frame_counter;

  // pair sweep
  logic [CW-1:0] i_idx, k_idx;
  logic [XW-1:0] a_reg;
  logic [XW-1:0] b_val;

  // pending and output events
  logic                         pend_valid;
  mahc_pkg::event_kind_t        pend_kind;
  logic [mahc_pkg::CHAN_W-1:0]  pend_chan;
  logic [mahc_pkg::FRAME_W-1:0] pend_frame;
  mahc_pkg::event_kind_t        out_kind;
  logic [mahc_pkg::CHAN_W-1:0]  out_chan;
  logic [mahc_pkg::FRAME_W-1:0] out_frame;
  logic                         out_free;
  logic                         move;

  logic [CW-1:0]  chi;
  logic [NW-1:0]  nch;
  logic [HW-1:0]  hl;
  logic           half_end;
  logic           win_end;

  assign chi = CW'(chn);

  // clamped channel count
  always_comb begin
    if (channel_count == '0) begin
      nch = NW'(1);
    end else if (NW'(channel_count) > NW'(MAX_CHANNELS)) begin
      nch = NW'(MAX_CHANNELS);
    end else begin
      nch = NW'(channel_count);
    end
  end

  // clamped half length
  always_comb begin
    if (window_half_length == '0) begin
      hl = HW'(1);
    end else if (HW'(window_half_length) > HW'(MAX_HALF_WINDOW)) begin
      hl = HW'(MAX_HALF_WINDOW);
    end else begin
      hl = HW'(window_half_length);
    end
  end

  assign half_end = (HW'(half_position) + HW'(1)) >= hl;
  assign win_end  = half_end && first_half_done;
  assign b_val    = (XW'(rdata) << 1) + XW'(rdata);
  assign out_free = !m_tvalid || m_tready;
  assign move     = pend_valid && (cmd.push || cmd.flush);
  assign prod     = smp * smp;

  // status to controller
  always_comb begin
    sts.in_range = NW'(s_tdata[mahc_pkg::S_CHAN_LSB +: mahc_pkg::CHAN_W]) < nch;
    sts.clip     = (smp == mahc_pkg::CLIP_POS) || (smp == mahc_pkg::CLIP_NEG) ||
                   (smp == mahc_pkg::SAMPLE_MIN);
    sts.zero_ev  = !(nz_prev[chi] || nz_now[chi]);
    sts.low_ev   = !(ab_prev[chi] || ab_now[chi]);
    sts.win_end  = win_end;
    sts.half_end = half_end;
    sts.last_ch  = NW'(chn) == (nch - NW'(1));
    sts.nch_ge2  = nch >= NW'(2);
    sts.imb      = a_reg < b_val;
    sts.k_last   = (NW'(k_idx) + NW'(1)) == nch;
    sts.i_last   = (NW'(i_idx) + NW'(2)) >= nch;
    sts.can_push = !pend_valid || out_free;
  end

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count      <= mahc_pkg::CHANNEL_COUNT_RST;
      window_half_length <= mahc_pkg::HALF_LENGTH_RST;
      level_threshold    <= mahc_pkg::THRESHOLD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        mahc_pkg::CFG_CHANNEL_COUNT: channel_count <= cfg_data[mahc_pkg::COUNT_W-1:0];
        mahc_pkg::CFG_HALF_LENGTH:   window_half_length <= cfg_data[mahc_pkg::HALF_W-1:0];
        mahc_pkg::CFG_THRESHOLD:     level_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  // input capture and square
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      smp <= s_tdata[mahc_pkg::S_SAMPLE_LSB +: SW];
      chn <= s_tdata[mahc_pkg::S_CHAN_LSB +: mahc_pkg::CHAN_W];
    end
    if (cmd.square) begin
      sq <= prod[mahc_pkg::SQ_W-1:0];
    end
  end

  // per-channel energy and flags
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < MAX_CHANNELS; c++) begin
        he_now[c]  <= '0;
        he_prev[c] <= '0;
      end
      nz_now  <= '0;
      nz_prev <= '0;
      ab_now  <= '0;
      ab_prev <= '0;
    end else if (cmd.accum) begin
      he_now[chi] <= he_now[chi] + EW'(sq);
      if (smp != '0) begin
        nz_now[chi] <= 1'b1;
      end
      if (smp > level_threshold) begin
        ab_now[chi] <= 1'b1;
      end
    end else if (cmd.shift) begin
      he_prev[chi] <= he_now[chi];
      he_now[chi]  <= '0;
      nz_prev[chi] <= nz_now[chi];
      nz_now[chi]  <= 1'b0;
      ab_prev[chi] <= ab_now[chi];
      ab_now[chi]  <= 1'b0;
    end
  end

  // window energy memory
  always_comb begin
    if (cmd.rd_i) begin
      raddr = i_idx;
    end else if (cmd.next_k) begin
      raddr = k_idx + CW'(1);
    end else begin
      raddr = k_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wsum) begin
      we_mem[chi] <= WW'(he_prev[chi]) + WW'(he_now[chi]);
    end
    rdata <= we_mem[raddr];
  end

  // pair sweep indexes and scaled left side
  always_ff @(posedge clk) begin
    if (cmd.pair_init) begin
      i_idx <= '0;
      k_idx <= CW'(1);
    end else if (cmd.next_i) begin
      i_idx <= i_idx + CW'(1);
      k_idx <= i_idx + CW'(2);
    end else if (cmd.next_k) begin
      k_idx <= k_idx + CW'(1);
    end
    if (cmd.load_a) begin
      a_reg <= (XW'(rdata) << 2) + XW'(rdata);
    end
  end

  // window position and frame count
  always_ff @(posedge clk) begin
    if (rst) begin
      half_position   <= '0;
      first_half_done <= 1'b0;
      frame_counter   <= '0;
    end else if (cmd.advance && sts.last_ch) begin
      if (half_end) begin
        half_position   <= '0;
        first_half_done <= 1'b1;
      end else begin
        half_position <= half_position + PW'(1);
      end
      frame_counter <= frame_counter + 1'b1;
    end
  end

  // pending event slot, one behind the output so last can be marked
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (cmd.push) begin
      pend_valid <= 1'b1;
    end else if (cmd.flush) begin
      pend_valid <= 1'b0;
    end
    if (cmd.push) begin
      pend_kind  <= cmd.kind;
      pend_chan  <= (cmd.kind == mahc_pkg::EV_IMBAL) ? mahc_pkg::CHAN_W'(i_idx) : chn;
      pend_frame <= frame_counter + 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (move) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (move) begin
      out_kind  <= pend_kind;
      out_chan  <= pend_chan;
      out_frame <= pend_frame;
      m_tlast   <= cmd.flush;
    end
  end

  assign m_tdata = {(mahc_pkg::M_TDATA_W - mahc_pkg::M_PAYLOAD_W)'(0),
                    out_frame, out_chan, out_kind};

endmodule

`default_nettype wire

// ===== sv/mahc_ctrl.sv =====
// ----------------------------------------------------------------------------
// mahc_ctrl
// Sequencer for one sample: square, accumulate, window events, pair sweep,
// then hand the last pending event out.
// ----------------------------------------------------------------------------
`default_nettype none

module mahc_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            s_tvalid,
  output logic                 s_tready,
  input  wire mahc_pkg::sts_t  sts,
  output mahc_pkg::cmd_t       cmd
);

  mahc_pkg::state_t state, state_next;

  logic zero_need, low_need, pair_go;

  assign zero_need = sts.win_end && sts.zero_ev;
  assign low_need  = sts.win_end && sts.low_ev;
  assign pair_go   = sts.last_ch && sts.win_end && sts.nch_ge2;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mahc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      mahc_pkg::ST_IDLE: begin
        if (s_tvalid && sts.in_range) begin
          state_next = mahc_pkg::ST_SQUARE;
        end
      end
      mahc_pkg::ST_SQUARE: begin
        if (!sts.clip || sts.can_push) begin
          state_next = mahc_pkg::ST_ACCUM;
        end
      end
      mahc_pkg::ST_ACCUM: state_next = mahc_pkg::ST_ZERO;
      mahc_pkg::ST_ZERO: begin
        if (!zero_need || sts.can_push) begin
          state_next = mahc_pkg::ST_LOW;
        end
      end
      mahc_pkg::ST_LOW: begin
        if (!low_need || sts.can_push) begin
          state_next = pair_go ? mahc_pkg::ST_RDI : mahc_pkg::ST_FLUSH;
        end
      end
      mahc_pkg::ST_RDI: state_next = mahc_pkg::ST_LDA;
      mahc_pkg::ST_LDA: state_next = mahc_pkg::ST_CMP;
      mahc_pkg::ST_CMP: begin
        if ((!sts.imb || sts.can_push) && sts.k_last) begin
          state_next = sts.i_last ? mahc_pkg::ST_FLUSH : mahc_pkg::ST_RDI;
        end
      end
      mahc_pkg::ST_FLUSH: begin
        if (sts.can_push) begin
          state_next = mahc_pkg::ST_IDLE;
        end
      end
      default: state_next = mahc_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    cmd.kind = mahc_pkg::EV_CLIP;
    s_tready = 1'b0;
    case (state)
      mahc_pkg::ST_IDLE: begin
        s_tready    = 1'b1;
        cmd.capture = s_tvalid;
      end
      mahc_pkg::ST_SQUARE: begin
        cmd.square = 1'b1;
        cmd.push   = sts.clip && sts.can_push;
        cmd.kind   = mahc_pkg::EV_CLIP;
      end
      mahc_pkg::ST_ACCUM: begin
        cmd.accum = 1'b1;
      end
      mahc_pkg::ST_ZERO: begin
        cmd.wsum = sts.win_end;
        cmd.push = zero_need && sts.can_push;
        cmd.kind = mahc_pkg::EV_ZERO;
      end
      mahc_pkg::ST_LOW: begin
        cmd.push = low_need && sts.can_push;
        cmd.kind = mahc_pkg::EV_LOW;
        if (!low_need || sts.can_push) begin
          cmd.shift     = sts.half_end;
          cmd.pair_init = pair_go;
        end
      end
      mahc_pkg::ST_RDI: begin
        cmd.rd_i = 1'b1;
      end
      mahc_pkg::ST_LDA: begin
        cmd.load_a = 1'b1;
      end
      mahc_pkg::ST_CMP: begin
        cmd.kind = mahc_pkg::EV_IMBAL;
        if (!sts.imb || sts.can_push) begin
          cmd.push   = sts.imb;
          cmd.next_i = sts.k_last;
          cmd.next_k = !sts.k_last;
        end
      end
      mahc_pkg::ST_FLUSH: begin
        cmd.flush   = sts.can_push;
        cmd.advance = sts.can_push;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/multichannel_audio_health_check_top.sv =====
// ----------------------------------------------------------------------------
// multichannel_audio_health_check_top
// Per-channel clip, silence, low-level and energy imbalance checker.
// ----------------------------------------------------------------------------
// Each beat on the input carries one sample of one channel; the block works on
// one sample at a time. A sample whose channel is outside the active count is
// dropped. Otherwise it steps through square, accumulate, two window event
// steps and a final hand-off when the output beat register is free; on the
// last channel of a frame at a window end the pair sweep adds a read and a
// load step per leading channel i and a compare step per pair (i, k). The
// sweep reads the window energy memory through its single registered read
// port, hence the separate read and load steps. Each result beat waits in an
// output register, so a stalled sink holds up the sequencer only when a
// second event is ready. The user must write configuration through the plain
// write port only while the block is idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module multichannel_audio_health_check_top #(
  parameter int MAX_CHANNELS    = mahc_pkg::MAX_CHANNELS_DEF,
  parameter int MAX_HALF_WINDOW = mahc_pkg::MAX_HALF_WINDOW_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // config write port
  input  wire logic                             cfg_we,
  input  wire logic [mahc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [mahc_pkg::CFG_DATA_W-1:0]  cfg_data,
  // sample stream
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [mahc_pkg::S_TDATA_W-1:0]   s_tdata,  // sample[15:0], channel[18:16]
  // event stream
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic [mahc_pkg::M_TDATA_W-1:0]        m_tdata,  // event_kind[1:0],
                                                          // event_channel[4:2],
                                                          // frame_index[36:5]
  output logic                                  m_tlast
);

  mahc_pkg::cmd_t cmd;
  mahc_pkg::sts_t sts;

  // sequencer
  mahc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // state and arithmetic
  mahc_datapath #(
    .MAX_CHANNELS    (MAX_CHANNELS),
    .MAX_HALF_WINDOW (MAX_HALF_WINDOW)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

`default_nettype wire

// ===== tb/tb_multichannel_audio_health_check_top.sv =====
// ----------------------------------------------------------------------------
// tb_multichannel_audio_health_check_top
// Self-checking bench for the multichannel audio health check block.
// ----------------------------------------------------------------------------
// A behavioral predictor tracks per-channel half-window energy, nonzero and
// above-threshold marks and the shared window position. Every accepted sample
// beat queues the events it should raise; each event beat is compared field by
// field against the oldest queued event. Directed tests cover clip limits,
// clamped and extreme register values, ignored channels and a full imbalance
// sweep; a long output stall fills the block; random phases then vary the
// configuration, channel amplitudes and stray or skipped channels, with random
// idle gaps on both streams.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_multichannel_audio_health_check_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mahc_pkg::*;

  localparam int RANDOM_ITEMS = 100;
  localparam int DRAIN_CYCLES = 64;
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int MAX_REPORTS  = 10;

  typedef struct {
    event_kind_t          kind;
    logic [CHAN_W-1:0]    chan;
    logic [FRAME_W-1:0]   frame;
    logic                 last;
  } health_event_t;

  // dut ports
  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [S_TDATA_W-1:0]   s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [M_TDATA_W-1:0]   m_tdata;
  logic                   m_tlast;

  // bench control
  health_event_t pending_events[$];
  int            error_count = 0;
  int            samples_taken = 0;
  int            cycle_count = 0;
  bit            src_steady = 1'b0;
  bit            sink_steady = 1'b0;
  bit            hold_request = 1'b0;

  // predictor copy of the registers
  logic [COUNT_W-1:0]         cfg_nch = CHANNEL_COUNT_RST;
  logic [HALF_W-1:0]          cfg_half = HALF_LENGTH_RST;
  logic signed [SAMPLE_W-1:0] cfg_thr = THRESHOLD_RST;

  // predictor copy of the channel state
  logic [ENERGY_W-1:0] hen_now [MAX_CHANNELS_DEF] = '{default: '0};
  logic [ENERGY_W-1:0] hen_prev[MAX_CHANNELS_DEF] = '{default: '0};
  logic [WIN_W-1:0]    win_sum [MAX_CHANNELS_DEF] = '{default: '0};
  bit                  win_valid[MAX_CHANNELS_DEF] = '{default: 1'b0};
  bit                  nz_now  [MAX_CHANNELS_DEF] = '{default: 1'b0};
  bit                  nz_prev [MAX_CHANNELS_DEF] = '{default: 1'b0};
  bit                  hi_now  [MAX_CHANNELS_DEF] = '{default: 1'b0};
  bit                  hi_prev [MAX_CHANNELS_DEF] = '{default: 1'b0};
  logic [10:0]         half_pos = '0;
  bit                  warmed = 1'b0;
  logic [FRAME_W-1:0]  frame_cnt = '0;

  multichannel_audio_health_check_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // effective channel count and half length after clamping
  function automatic int eff_channels();
    int n;
    n = int'(cfg_nch);
    if (n < 1) n = 1;
    if (n > MAX_CHANNELS_DEF) n = MAX_CHANNELS_DEF;
    return n;
  endfunction

  function automatic int eff_half();
    int n;
    n = int'(cfg_half);
    if (n < 1) n = 1;
    if (n > MAX_HALF_WINDOW_DEF) n = MAX_HALF_WINDOW_DEF;
    return n;
  endfunction

  function automatic bit half_closes();
    return int'(half_pos) + 1 >= eff_half();
  endfunction

  // keep the pair sweep away from window sums that were never stored
  function automatic logic [CHAN_W-1:0] safe_channel(input logic [CHAN_W-1:0] ch);
    int nch;
    nch = eff_channels();
    if (int'(ch) == nch - 1 && warmed && half_closes()) begin
      for (int j = 0; j < nch - 1; j++)
        if (!win_valid[j]) return '0;
    end
    return ch;
  endfunction

  function automatic health_event_t make_event(input event_kind_t kind,
                                               input logic [CHAN_W-1:0] ch);
    health_event_t ev;
    ev.kind  = kind;
    ev.chan  = ch;
    ev.frame = frame_cnt + 1;
    ev.last  = 1'b0;
    return ev;
  endfunction

  // idle length: mostly none or short, a few long
  function automatic int idle_len(input bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // sample by amplitude class: zero, tiny, moderate, full range, clip level
  function automatic logic signed [SAMPLE_W-1:0] draw_sample(input int cls);
    logic signed [SAMPLE_W-1:0] v;
    case (cls)
      0: v = '0;
      1: v = SAMPLE_W'(int'($urandom_range(0, 32)) - 16);
      2: v = SAMPLE_W'(int'($urandom_range(0, 4000)) - 2000);
      3: v = SAMPLE_W'($urandom);
      default: begin
        case ($urandom_range(0, 3))
          0: v = CLIP_POS;
          1: v = CLIP_NEG;
          2: v = SAMPLE_MIN;
          default: v = CLIP_POS - 1;
        endcase
      end
    endcase
    return v;
  endfunction

  // work out the events of one accepted sample and update the state
  task automatic predict_events(input logic signed [SAMPLE_W-1:0] smp,
                                input logic [CHAN_W-1:0] ch);
    health_event_t     found[$];
    logic signed [31:0] prod;
    int                nch;
    bit                half_end;
    bit                win_end;
    nch = eff_channels();
    if (int'(ch) >= nch) return;
    samples_taken++;

    if (smp >= CLIP_POS || smp <= CLIP_NEG) found.push_back(make_event(EV_CLIP, ch));

    prod = smp * smp;
    hen_now[ch] = hen_now[ch] + ENERGY_W'(prod);
    if (smp != 0) nz_now[ch] = 1'b1;
    if (smp > cfg_thr) hi_now[ch] = 1'b1;

    half_end = half_closes();
    win_end  = half_end && warmed;

    // window end checks for this channel
    if (win_end) begin
      win_sum[ch]   = WIN_W'(hen_prev[ch]) + WIN_W'(hen_now[ch]);
      win_valid[ch] = 1'b1;
      if (!(nz_prev[ch] || nz_now[ch])) found.push_back(make_event(EV_ZERO, ch));
      if (!(hi_prev[ch] || hi_now[ch])) found.push_back(make_event(EV_LOW, ch));
    end
    if (half_end) begin
      hen_prev[ch] = hen_now[ch];
      hen_now[ch]  = '0;
      nz_prev[ch]  = nz_now[ch];
      nz_now[ch]   = 1'b0;
      hi_prev[ch]  = hi_now[ch];
      hi_now[ch]   = 1'b0;
    end

    // pair sweep and frame advance on the last active channel
    if (int'(ch) == nch - 1) begin
      if (win_end) begin
        for (int i = 0; i < nch; i++)
          for (int k = i + 1; k < nch; k++)
            if (64'(win_sum[i]) * 5 < 64'(win_sum[k]) * 3)
              found.push_back(make_event(EV_IMBAL, CHAN_W'(i)));
      end
      if (half_end) begin
        half_pos = '0;
        warmed   = 1'b1;
      end else begin
        half_pos = half_pos + 1'b1;
      end
      frame_cnt = frame_cnt + 1;
    end

    if (found.size() > 0) found[found.size() - 1].last = 1'b1;
    foreach (found[n]) pending_events.push_back(found[n]);
  endtask

  // offer one sample beat and wait for it to be taken
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] smp,
                             input logic [CHAN_W-1:0] ch_req);
    logic [CHAN_W-1:0] ch;
    int                gap;
    ch  = safe_channel(ch_req);
    gap = idle_len(src_steady);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tdata  <= {{(S_TDATA_W - S_CHAN_LSB - CHAN_W){1'b0}}, ch, smp};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    predict_events(smp, ch);
  endtask

  // drop the source, wait for every queued event, then let the block go quiet
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_events.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // write all three registers on consecutive cycles
  task automatic load_config(input logic [CFG_DATA_W-1:0] count_word,
                             input logic [CFG_DATA_W-1:0] half_word,
                             input logic [CFG_DATA_W-1:0] thr_word);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_CHANNEL_COUNT;
    cfg_data  <= count_word;
    @(posedge clk);
    cfg_index <= CFG_HALF_LENGTH;
    cfg_data  <= half_word;
    @(posedge clk);
    cfg_index <= CFG_THRESHOLD;
    cfg_data  <= thr_word;
    @(posedge clk);
    cfg_we   <= 1'b0;
    cfg_nch  = count_word[COUNT_W-1:0];
    cfg_half = half_word[HALF_W-1:0];
    cfg_thr  = thr_word;
  endtask

  // reset config: clip limits, frame count, out-of-range channel ignored
  task automatic test_clip_and_ignore();
    send_sample(CLIP_POS, 3'd0);
    send_sample(SAMPLE_MIN, 3'd1);
    send_sample(CLIP_NEG, 3'd0);
    send_sample(CLIP_POS - 1, 3'd1);
    send_sample('0, 3'd5);
  endtask

  // zero count and zero half length clamp to one; half shrinks below position
  task automatic test_clamped_config();
    settle();
    load_config(16'd0, 16'd0, 16'h8000);
    send_sample('0, 3'd0);
    send_sample('0, 3'd0);
    send_sample('0, 3'd0);
    send_sample(SAMPLE_MIN, 3'd0);
    send_sample(SAMPLE_MIN, 3'd0);
    send_sample(16'sd9, 3'd3);
  endtask

  // counts and half length above range clamp; then an eight channel sweep
  task automatic test_wide_config();
    logic signed [SAMPLE_W-1:0] first_frame [MAX_CHANNELS_DEF];
    logic signed [SAMPLE_W-1:0] sweep_frame [MAX_CHANNELS_DEF];
    first_frame = '{16'sd0, -16'sd1, 16'sd200, -16'sd3000,
                    16'sd12000, -16'sd20000, 16'sd32767, 16'sd5};
    sweep_frame = '{16'sd0, 16'sd1, -16'sd200, 16'sd3000,
                    -16'sd12000, 16'sd20000, -16'sd32768, 16'sd30000};
    settle();
    load_config(16'hfff, 16'hffff, 16'h7fff);
    for (int c = 0; c < MAX_CHANNELS_DEF; c++) send_sample(first_frame[c], CHAN_W'(c));
    settle();
    load_config(16'd8, 16'd2, 16'h7fff);
    for (int c = 0; c < MAX_CHANNELS_DEF; c++) send_sample(sweep_frame[c], CHAN_W'(c));
  endtask

  // long sink hold-off while full frames keep coming
  task automatic test_output_backpressure();
    settle();
    load_config(16'd8, 16'd1, 16'h7fff);
    src_steady   = 1'b1;
    hold_request = 1'b1;
    repeat (3) begin
      for (int c = 0; c < MAX_CHANNELS_DEF; c++)
        send_sample(draw_sample($urandom_range(0, 4)), CHAN_W'(c));
    end
    src_steady = 1'b0;
  endtask

  // random phases: new settings, per-channel amplitudes, stray and skipped beats
  task automatic test_random_phases();
    int                   amp_class[MAX_CHANNELS_DEF];
    int                   start;
    int                   frames;
    int                   nch;
    logic [COUNT_W-1:0]   count_val;
    logic [HALF_W-1:0]    half_val;
    logic [SAMPLE_W-1:0]  thr_val;
    start = samples_taken;
    while (samples_taken - start < RANDOM_ITEMS) begin
      settle();
      src_steady  = ($urandom_range(0, 3) == 0);
      sink_steady = ($urandom_range(0, 3) == 0);

      case ($urandom_range(0, 9))
        0: count_val = 4'd0;
        1: count_val = 4'd15;
        2: count_val = 4'd1;
        3, 4, 5: count_val = 4'd8;
        default: count_val = COUNT_W'($urandom_range(2, 7));
      endcase
      case ($urandom_range(0, 19))
        0: half_val = 12'd0;
        1: half_val = 12'd2048;
        2: half_val = 12'd4095;
        3, 4, 5: half_val = HALF_W'($urandom_range(4, 12));
        default: half_val = HALF_W'($urandom_range(1, 3));
      endcase
      case ($urandom_range(0, 4))
        0: thr_val = 16'h8000;
        1: thr_val = 16'h7fff;
        2: thr_val = 16'h0000;
        3: thr_val = SAMPLE_W'($urandom);
        default: thr_val = SAMPLE_W'(int'($urandom_range(0, 100)) - 50);
      endcase
      // unused upper bits of the write data carry junk
      load_config({12'($urandom), count_val}, {4'($urandom), half_val}, thr_val);

      foreach (amp_class[c]) amp_class[c] = $urandom_range(0, 4);
      nch    = eff_channels();
      frames = (eff_half() > 16) ? 2 : $urandom_range(2, 6);
      repeat (frames) begin
        for (int c = 0; c < nch; c++) begin
          if ($urandom_range(0, 99) < 8)
            send_sample(draw_sample(3), CHAN_W'($urandom_range(0, 7)));
          if ($urandom_range(0, 99) >= 5)
            send_sample(draw_sample(($urandom_range(0, 9) == 0) ? 3 : amp_class[c]),
                        CHAN_W'(c));
        end
      end
      src_steady  = 1'b0;
      sink_steady = 1'b0;
    end
  endtask

  // sink pacing: random stalls, plus the requested long hold-off
  initial begin : sink_pacing
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left   = HOLD_CYCLES;
      end else if (stall_left == 0 && $urandom_range(0, 3) == 0) begin
        stall_left = idle_len(sink_steady);
      end
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // compare each event beat with the oldest queued event
  initial begin : event_checker
    health_event_t       want;
    logic [KIND_W-1:0]   got_kind;
    logic [CHAN_W-1:0]   got_chan;
    logic [FRAME_W-1:0]  got_frame;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        got_kind  = m_tdata[KIND_W-1:0];
        got_chan  = m_tdata[KIND_W +: CHAN_W];
        got_frame = m_tdata[KIND_W + CHAN_W +: FRAME_W];
        if (pending_events.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("unexpected event: kind %0d ch %0d frame %0d last %0b",
                     got_kind, got_chan, got_frame, m_tlast);
        end else begin
          want = pending_events.pop_front();
          if (got_kind !== want.kind || got_chan !== want.chan ||
              got_frame !== want.frame || m_tlast !== want.last) begin
            error_count++;
            if (error_count <= MAX_REPORTS) begin
              $write("event mismatch: expected kind %0d ch %0d frame %0d last %0b, ",
                     want.kind, want.chan, want.frame, want.last);
              $display("got kind %0d ch %0d frame %0d last %0b",
                       got_kind, got_chan, got_frame, m_tlast);
            end
          end
        end
      end
    end
  end

  // run limit
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // test sequence
  initial begin : main_seq
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_clip_and_ignore();
    test_clamped_config();
    test_wide_config();
    test_output_backpressure();
    test_random_phases();
    settle();
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
sv/mahc_pkg.sv
sv/mahc_datapath.sv
sv/mahc_ctrl.sv
sv/multichannel_audio_health_check_top.sv
tb/tb_multichannel_audio_health_check_top.sv
